### design/rc_link_frame_resync_parser_defines.svh
// Assertion macros shared by the parser RTL
`ifndef RC_LINK_FRAME_RESYNC_PARSER_DEFINES_SVH
`define RC_LINK_FRAME_RESYNC_PARSER_DEFINES_SVH

// same-cycle implication, clocked on clk, held off during reset
`define RCLFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RCLFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/rclfr_pkg.sv
// ----------------------------------------------------------------------------
// rclfr_pkg
// Types, constants and the CRC-8 byte fold of the RC link frame parser.
// ----------------------------------------------------------------------------
package rclfr_pkg;

    localparam logic [7:0] LEN_MIN = 8'd2;
    localparam logic [7:0] LEN_MAX = 8'd62;

    localparam logic [1:0] REG_CRC_POLY   = 2'd0;
    localparam logic [1:0] REG_SYNC_PRI   = 2'd1;
    localparam logic [1:0] REG_SYNC_SEC   = 2'd2;

    localparam logic [7:0] CRC_POLY_RST   = 8'd213;
    localparam logic [7:0] SYNC_PRI_RST   = 8'd200;
    localparam logic [7:0] SYNC_SEC_RST   = 8'd238;

    typedef logic [7:0] byte_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic  shift;
        logic  load;
        byte_t wr_data;
    } cell_ctrl_t;

    // MSB-first CRC-8 over one byte
    function automatic byte_t crc_fold(input byte_t crc, input byte_t data,
                                       input byte_t poly);
        byte_t c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/rclfr_if.sv
// ----------------------------------------------------------------------------
// rclfr_in_if / rclfr_out_if
// Valid/ready channels for received bytes and for frame bytes.
// ----------------------------------------------------------------------------
interface rclfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface rclfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic       last_byte;

    modport source (output valid, output frame_byte, output byte_index,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input last_byte, output ready);
endinterface

### design/rclfr_cell.sv
// ----------------------------------------------------------------------------
// rclfr_cell
// One byte of the frame store; shifts from its neighbour or takes a new byte.
// ----------------------------------------------------------------------------
module rclfr_cell
    import rclfr_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       sel,
    input  byte_t      neighbour,
    output byte_t      data
);

    byte_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= neighbour;
        end
        else if (ctrl.load && sel)
        begin
            data_reg <= ctrl.wr_data;
        end
    end

    assign data = data_reg;

endmodule

### design/rc_link_frame_resync_parser.sv
// ----------------------------------------------------------------------------
// rc_link_frame_resync_parser
// Serial RC link frame parser with CRC-8 check and resync.
// ----------------------------------------------------------------------------
// Bytes are held in a row of MAX_FRAME_BYTES cells that rotate towards cell 0;
// all checks look at cell 0 and cell 1 only. An input word that leaves a
// partial frame is loaded in ST_IDLE and judged in ST_JUDGE. A complete frame
// needs one full rotation of the row for the CRC, then its bytes are sent from
// cell 0 whenever the output register can take one. Each resync step drops
// one head byte. A new byte is taken only while the parser is idle; the last
// frame word may still wait in the output register.
module rc_link_frame_resync_parser
    import rclfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    rclfr_in_if.sink          byte_in,
    rclfr_out_if.source       frame_out,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

`include "rc_link_frame_resync_parser_defines.svh"

    localparam int FW   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMPW = (FW > 9) ? FW + 1 : 10;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_JUDGE = 2'd1;
    localparam logic [1:0] ST_CRC   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] t_reg, t_next;
    byte_t         crc_reg, crc_next;
    logic          match_reg, match_next;
    logic          bad_reg, bad_next;
    byte_t         poly_reg, sync_pri_reg, sync_sec_reg;

    logic          out_valid_reg, out_valid_next;
    byte_t         out_byte_reg;
    logic [5:0]    out_idx_reg;
    logic          out_last_reg;

    cell_ctrl_t    ctrl;
    byte_t         cell_data [MAX_FRAME_BYTES];
    logic [FW-1:0] fill_eff;

    // ---- cell row ----
    assign fill_eff = (fill_reg == FW'(MAX_FRAME_BYTES)) ? '0 : fill_reg;

    for (genvar i = 0; i < MAX_FRAME_BYTES; i++)
    begin : g_cell
        rclfr_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .sel       (fill_eff == FW'(i)),
            .neighbour (cell_data[(i + 1) % MAX_FRAME_BYTES]),
            .data      (cell_data[i])
        );
    end

    // ---- frame checks on the head of the row ----
    byte_t          c0, c1;
    logic           sync0, len_ok, is_partial, is_full, is_invalid;
    logic [CMPW-1:0] tot, nx;

    assign c0     = cell_data[0];
    assign c1     = cell_data[1];
    assign sync0  = (c0 == sync_pri_reg) || (c0 == sync_sec_reg);
    assign len_ok = (c1 >= LEN_MIN) && (c1 <= LEN_MAX);
    assign tot    = CMPW'(c1) + CMPW'(2);
    assign nx     = CMPW'(fill_reg);

    always_comb
    begin
        is_invalid = 1'b0;
        is_partial = 1'b0;
        is_full    = 1'b0;
        if (bad_reg || !sync0)
        begin
            is_invalid = 1'b1;
        end
        else if (fill_reg < FW'(2))
        begin
            is_partial = 1'b1;
        end
        else if (!len_ok)
        begin
            is_invalid = 1'b1;
        end
        else if (nx < tot)
        begin
            is_partial = 1'b1;
        end
        else if (nx > tot)
        begin
            is_invalid = 1'b1;
        end
        else
        begin
            is_full = 1'b1;
        end
    end

    logic emit_go, emit_last, match_now;
    assign emit_go   = !out_valid_reg || frame_out.ready;
    assign emit_last = (t_reg + FW'(1)) == fill_reg;
    assign match_now = (t_reg == fill_reg - FW'(1)) ? (crc_reg == c0) : match_reg;

    assign byte_in.ready = (state_reg == ST_IDLE);

    // ---- sequencer ----
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        t_next         = t_reg;
        crc_next       = crc_reg;
        match_next     = match_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !frame_out.ready;
        ctrl.shift     = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.wr_data   = byte_in.in_byte;
        case (state_reg)
            ST_IDLE:
            begin
                if (byte_in.valid)
                begin
                    ctrl.load  = 1'b1;
                    fill_next  = fill_eff + FW'(1);
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                bad_next = 1'b0;
                if (is_invalid)
                begin
                    // drop the head word and look at the next offset
                    if (fill_reg == FW'(1))
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctrl.shift = 1'b1;
                        fill_next  = fill_reg - FW'(1);
                    end
                end
                else if (is_partial)
                begin
                    state_next = ST_IDLE;
                end
                else if (is_full)
                begin
                    t_next     = '0;
                    crc_next   = '0;
                    match_next = 1'b0;
                    state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                // full rotation; word t sits in cell 0 at step t
                ctrl.shift = 1'b1;
                t_next     = t_reg + FW'(1);
                if (t_reg >= FW'(2) && (t_reg + FW'(2)) <= fill_reg)
                begin
                    crc_next = crc_fold(crc_reg, c0, poly_reg);
                end
                match_next = match_now;
                if (t_reg == FW'(MAX_FRAME_BYTES - 1))
                begin
                    t_next = '0;
                    if (match_now)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_JUDGE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    ctrl.shift     = 1'b1;
                    out_valid_next = 1'b1;
                    t_next         = t_reg + FW'(1);
                    if (emit_last)
                    begin
                        fill_next  = '0;
                        t_next     = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            t_reg         <= '0;
            match_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            poly_reg      <= CRC_POLY_RST;
            sync_pri_reg  <= SYNC_PRI_RST;
            sync_sec_reg  <= SYNC_SEC_RST;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            t_reg         <= t_next;
            match_reg     <= match_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CRC_POLY: poly_reg     <= cfg_data;
                    REG_SYNC_PRI: sync_pri_reg <= cfg_data;
                    REG_SYNC_SEC: sync_sec_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (state_reg == ST_EMIT && emit_go)
        begin
            out_byte_reg <= c0;
            out_idx_reg  <= 6'(t_reg);
            out_last_reg <= emit_last;
        end
    end

    assign frame_out.valid      = out_valid_reg;
    assign frame_out.frame_byte = out_byte_reg;
    assign frame_out.byte_index = out_idx_reg;
    assign frame_out.last_byte  = out_last_reg;

    // ---- checks ----
    `RCLFR_ASSERT_NXT(a_accept_judge, byte_in.valid && byte_in.ready, state_reg == ST_JUDGE)
    `RCLFR_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FW'(MAX_FRAME_BYTES))
    `RCLFR_ASSERT_IMP(a_crc_min_len, state_reg == ST_CRC, fill_reg >= FW'(4))
    `RCLFR_ASSERT_NXT(a_emit_done, state_reg == ST_EMIT && emit_go && emit_last, fill_reg == '0 && state_reg == ST_IDLE && frame_out.valid && frame_out.last_byte)

endmodule

### verif/rclfr_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfr_tb_if
// Configuration write port driven by the test; the channel interfaces come
// from the design files.
// ----------------------------------------------------------------------------
interface rclfr_tb_if;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
endinterface

### verif/rc_link_frame_resync_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_resync_parser_test
// Drives received bytes into the frame parser, predicts the frames that the
// parser should release (including after resync) and checks every frame word.
// ----------------------------------------------------------------------------
module rc_link_frame_resync_parser_test;
    import rclfr_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_index;
        logic       last_byte;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rclfr_in_if  byte_in ();
    rclfr_out_if frame_out ();
    rclfr_tb_if  cfg ();

    rc_link_frame_resync_parser uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in.sink),
        .frame_out (frame_out.source),
        .cfg_we    (cfg.cfg_we),
        .cfg_index (cfg.cfg_index),
        .cfg_data  (cfg.cfg_data)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [7:0] poly_now = CRC_POLY_RST;
    logic [7:0] sync_pri_now = SYNC_PRI_RST;
    logic [7:0] sync_sec_now = SYNC_SEC_RST;
    logic [7:0] held [STORE_DEPTH];
    int held_count = 0;
    frame_word_t pending_words [$];

    int fail_count = 0;
    int idle_cycles = 0;
    bit long_hold = 1'b0;
    bit stall_enable = 1'b1;

    function automatic bit sync_match(logic [7:0] b);
        return b == sync_pri_now || b == sync_sec_now;
    endfunction

    function automatic logic [7:0] crc_over(logic [7:0] p, logic [7:0] q [$]);
        logic [7:0] c;
        c = 8'd0;
        foreach (q[k])
        begin
            c = c ^ q[k];
            for (int b = 0; b < 8; b++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ p) : {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // 0 invalid, 1 partial, 2 valid
    function automatic int window_verdict(int start, int n);
        int flen;
        logic [7:0] body [$];
        if (n == 0 || !sync_match(held[start]))
        begin
            return 0;
        end
        if (n < 2)
        begin
            return 1;
        end
        flen = held[start + 1];
        if (flen < LEN_MIN || flen > LEN_MAX)
        begin
            return 0;
        end
        if (n < flen + 2)
        begin
            return 1;
        end
        if (n > flen + 2)
        begin
            return 0;
        end
        for (int k = 0; k < n - 3; k++)
        begin
            body.push_back(held[start + 2 + k]);
        end
        return (crc_over(poly_now, body) == held[start + n - 1]) ? 2 : 0;
    endfunction

    function automatic void predict_frames(logic [7:0] b);
        int verdict;
        bit found;
        if (held_count >= STORE_DEPTH)
        begin
            held_count = 0;
        end
        held[held_count] = b;
        held_count++;
        verdict = window_verdict(0, held_count);
        if (verdict == 0)
        begin
            found = 1'b0;
            for (int k = 1; k < held_count && !found; k++)
            begin
                if (sync_match(held[k]))
                begin
                    verdict = window_verdict(k, held_count - k);
                    if (verdict != 0)
                    begin
                        for (int j = 0; j < held_count - k; j++)
                        begin
                            held[j] = held[j + k];
                        end
                        held_count -= k;
                        found = 1'b1;
                    end
                end
            end
            if (!found)
            begin
                held_count = 0;
                return;
            end
        end
        if (verdict == 2)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                pending_words.push_back({held[k], 6'(k), k + 1 == held_count});
            end
            held_count = 0;
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        byte_in.valid <= 1'b1;
        byte_in.in_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!byte_in.ready);
        predict_frames(b);
        // burst/gap pattern
        if ($urandom_range(0, 3) == 0)
        begin
            byte_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_frame(logic [7:0] sync_b, int flen, bit corrupt);
        logic [7:0] body [$];
        logic [7:0] c;
        for (int k = 0; k < flen - 1; k++)
        begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        c = crc_over(poly_now, body);
        if (corrupt)
        begin
            c = c ^ 8'(1 << $urandom_range(0, 7));
        end
        send_byte(sync_b);
        send_byte(8'(flen));
        foreach (body[k])
        begin
            send_byte(body[k]);
        end
        send_byte(c);
    endtask

    task automatic drain();
        byte_in.valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        // a trailing resync or rotation may still be running
        repeat (STORE_DEPTH * STORE_DEPTH + 200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        cfg.cfg_we <= 1'b1;
        cfg.cfg_index <= idx;
        cfg.cfg_data <= v;
        @(posedge clk);
        cfg.cfg_we <= 1'b0;
        case (idx)
            REG_CRC_POLY: poly_now = v;
            REG_SYNC_PRI: sync_pri_now = v;
            default:      sync_sec_now = v;
        endcase
    endtask

    function automatic logic [7:0] pick_sync();
        return $urandom_range(0, 1) ? sync_pri_now : sync_sec_now;
    endfunction

    task automatic test_directed();
        send_frame(sync_pri_now, LEN_MIN, 1'b0);
        send_frame(sync_sec_now, 5, 1'b0);
        send_frame(sync_pri_now, 4, 1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sync_pri_now);
        send_byte(8'd63);
        send_byte(sync_sec_now);
        send_byte(8'd1);
        send_frame(sync_pri_now, 3, 1'b0);
        drain();
    endtask

    task automatic test_long_frames();
        send_frame(sync_sec_now, LEN_MAX, 1'b0);
        send_frame(sync_pri_now, LEN_MAX, 1'b1);
        drain();
        // store full: 64 random bytes after a sync and a length byte
        send_byte(sync_pri_now);
        send_byte(8'd62);
        for (int k = 0; k < 64; k++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    task automatic test_backpressure();
        fork
        begin
            long_hold = 1'b1;
            repeat (2000) @(posedge clk);
            long_hold = 1'b0;
        end
        begin
            send_frame(pick_sync(), 6, 1'b0);
            send_frame(pick_sync(), 2, 1'b0);
            byte_in.valid <= 1'b0;
        end
        join
        drain();
    endtask

    task automatic test_random(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                int flen;
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 62)
                                                   : $urandom_range(2, 10);
                send_frame(pick_sync(), flen, $urandom_range(0, 5) == 0);
                sent += flen + 2;
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_config();
        write_reg(REG_CRC_POLY, 8'h07);
        write_reg(REG_SYNC_PRI, 8'h00);
        write_reg(REG_SYNC_SEC, 8'hFF);
        test_random(20);
        write_reg(REG_CRC_POLY, 8'hFF);
        write_reg(REG_SYNC_PRI, 8'hFF);
        write_reg(REG_SYNC_SEC, 8'hFF);
        test_random(15);
        write_reg(REG_CRC_POLY, 8'h00);
        write_reg(REG_SYNC_PRI, 8'h5A);
        write_reg(REG_SYNC_SEC, 8'hA5);
        test_random(15);
        write_reg(REG_CRC_POLY, CRC_POLY_RST);
        write_reg(REG_SYNC_PRI, SYNC_PRI_RST);
        write_reg(REG_SYNC_SEC, SYNC_SEC_RST);
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (long_hold)
        begin
            frame_out.ready <= 1'b0;
        end
        else if (!stall_enable)
        begin
            frame_out.ready <= 1'b1;
        end
        else
        begin
            frame_out.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_in.valid && byte_in.ready) || (frame_out.valid && frame_out.ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            if (frame_out.valid && frame_out.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("unexpected frame word %h", frame_out.frame_byte);
                    fail_count++;
                end
                else
                begin
                    frame_word_t w;
                    w = pending_words.pop_front();
                    if (w.frame_byte !== frame_out.frame_byte)
                    begin
                        $error("frame_byte exp %h got %h", w.frame_byte,
                               frame_out.frame_byte);
                        fail_count++;
                    end
                    if (w.byte_index !== frame_out.byte_index)
                    begin
                        $error("byte_index exp %0d got %0d", w.byte_index,
                               frame_out.byte_index);
                        fail_count++;
                    end
                    if (w.last_byte !== frame_out.last_byte)
                    begin
                        $error("last_byte exp %0d got %0d", w.last_byte,
                               frame_out.last_byte);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        byte_in.valid = 1'b0;
        byte_in.in_byte = 8'd0;
        frame_out.ready = 1'b0;
        cfg.cfg_we = 1'b0;
        cfg.cfg_index = REG_CRC_POLY;
        cfg.cfg_data = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_CRC_POLY, CRC_POLY_RST);
        test_directed();
        test_long_frames();
        test_backpressure();
        stall_enable = 1'b0;
        test_random(20);
        stall_enable = 1'b1;
        test_config();
        test_random(15);
        if (pending_words.size() != 0)
        begin
            $error("%0d frame words never arrived", pending_words.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
